// ----- src/vrp_pkg.sv -----
// ----------------------------------------------------------------------------
// vrp_pkg: shared definitions for the vertex rotate and project block
// Register map indexes, reset values and the sine polynomial constants.
// ----------------------------------------------------------------------------
package vrp_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ANGLE_WIDTH_DEF = 16;

	localparam int CFG_ADDR_WIDTH = 5;
	localparam int CFG_DATA_WIDTH = 32;

	localparam int FOCAL_WIDTH  = 10;
	localparam int CENTER_WIDTH = 12;
	localparam int DEPTH_WIDTH  = 15;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_YAW      = 3'd0;
	localparam logic [2:0] REG_PITCH    = 3'd1;
	localparam logic [2:0] REG_FOCAL    = 3'd2;
	localparam logic [2:0] REG_CENTER_X = 3'd3;
	localparam logic [2:0] REG_CENTER_Y = 3'd4;
	localparam logic [2:0] REG_DEPTH    = 3'd5;

	localparam logic [FOCAL_WIDTH-1:0]  FOCAL_RESET    = 10'd300;
	localparam logic [CENTER_WIDTH-1:0] CENTER_X_RESET = 12'd320;
	localparam logic [CENTER_WIDTH-1:0] CENTER_Y_RESET = 12'd240;
	localparam logic [DEPTH_WIDTH-1:0]  DEPTH_RESET    = 15'd20480;

	// Quarter-wave sine polynomial, Q14 operands.
	localparam logic [14:0] TRIG_ONE = 15'd16384;
	localparam logic [14:0] POLY_A   = 15'd25736;
	localparam logic [13:0] POLY_B   = 14'd10512;
	localparam logic [10:0] POLY_C   = 11'd1160;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	// Cycles from a register write until the sine and cosine values settle.
	localparam int TRIG_LATENCY = 5;

endpackage

// ----- src/vertex_rotate_project.sv -----
// ----------------------------------------------------------------------------
// vertex_rotate_project: rotation and perspective projection of vertices
// Rotates a Q4.12 vertex by yaw then pitch and projects it to Q12.4 pixels.
// ----------------------------------------------------------------------------
// Usage. Vertices arrive on the slave stream (s_tvalid, s_tready, s_tdata) and
// projected points leave on the master stream (m_tvalid, m_tready, m_tdata,
// m_tuser). A transaction is taken at each rising edge where tvalid and tready
// are both high. Every vertex gives exactly one result, in order.
// The pipeline accepts one vertex per clock while the output is not stalled.
// It holds six stages in which the vertex waits for sine and cosine to
// settle, four rotation stages, a depth and focal stage, the restoring divider,
// which retires one quotient bit per stage over COORD_WIDTH + 22 stages, a sign
// stage and the output register.
// When the receiver stalls, the whole pipeline holds: s_tready follows the
// output register, so a new vertex is still taken while the output register is
// empty or being emptied, and nothing is lost or repeated.
// The APB port sets yaw, pitch, focal length, screen centre and depth offset.
// Write these only while no vertex is in flight; sine and cosine follow a
// write. Reset empties the pipeline and loads the default registers (focal
// 300, centre 320 by 240, depth offset 5.0).
// ----------------------------------------------------------------------------
module vertex_rotate_project #(
	parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = vrp_pkg::ANGLE_WIDTH_DEF,
	localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Vertex input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [IN_W-1:0]                     s_tdata,  // vertex_x, vertex_y, vertex_z
	// Projected point output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [OUT_W-1:0]                    m_tdata,  // screen_x, screen_y
	output logic [1:0]                          m_tuser,  // behind_camera, clipped
	// Register port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vrp_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
	input  logic [vrp_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
	output logic [vrp_pkg::CFG_DATA_WIDTH-1:0]  prdata,
	output logic                                pready
);

	localparam int W    = COORD_WIDTH;
	localparam int DLY  = vrp_pkg::TRIG_LATENCY + 1;  // vertex waits for the trig values
	localparam int XW   = W + 3;                       // yaw-rotated coordinates
	localparam int YW   = W + 6;                       // pitch-rotated coordinates
	localparam int DW   = W + 7;                       // signed depth
	localparam int DVW  = W + 6;                       // divisor magnitude
	localparam int QW   = W + 22;                      // dividend and quotient
	localparam int SW   = QW + 2;                      // final sum
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	// ------------------------------------------------------------------
	// Configuration registers. The port never inserts wait states.
	// ------------------------------------------------------------------
	logic [ANGLE_WIDTH-1:0]           yaw_q;
	logic [ANGLE_WIDTH-1:0]           pitch_q;
	logic [vrp_pkg::FOCAL_WIDTH-1:0]  focal_q;
	logic [vrp_pkg::CENTER_WIDTH-1:0] center_x_q;
	logic [vrp_pkg::CENTER_WIDTH-1:0] center_y_q;
	logic [vrp_pkg::DEPTH_WIDTH-1:0]  depth_q;
	logic                             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q      <= '0;
			pitch_q    <= '0;
			focal_q    <= vrp_pkg::FOCAL_RESET;
			center_x_q <= vrp_pkg::CENTER_X_RESET;
			center_y_q <= vrp_pkg::CENTER_Y_RESET;
			depth_q    <= vrp_pkg::DEPTH_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				vrp_pkg::REG_YAW:      yaw_q      <= pwdata[ANGLE_WIDTH-1:0];
				vrp_pkg::REG_PITCH:    pitch_q    <= pwdata[ANGLE_WIDTH-1:0];
				vrp_pkg::REG_FOCAL:    focal_q    <= pwdata[vrp_pkg::FOCAL_WIDTH-1:0];
				vrp_pkg::REG_CENTER_X: center_x_q <= pwdata[vrp_pkg::CENTER_WIDTH-1:0];
				vrp_pkg::REG_CENTER_Y: center_y_q <= pwdata[vrp_pkg::CENTER_WIDTH-1:0];
				vrp_pkg::REG_DEPTH:    depth_q    <= pwdata[vrp_pkg::DEPTH_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			vrp_pkg::REG_YAW:      prdata = 32'(yaw_q);
			vrp_pkg::REG_PITCH:    prdata = 32'($signed(pitch_q));
			vrp_pkg::REG_FOCAL:    prdata = 32'(focal_q);
			vrp_pkg::REG_CENTER_X: prdata = 32'(center_x_q);
			vrp_pkg::REG_CENTER_Y: prdata = 32'(center_y_q);
			vrp_pkg::REG_DEPTH:    prdata = 32'(depth_q);
			default:               prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sine and cosine. The user must change the angles only while the block is idle; the
	// block does not enforce this. These four units run freely from the registers and are not stalled.
	// Unit 0 is sin(yaw), 1 cos(yaw), 2 sin(pitch), 3 cos(pitch).
	// ------------------------------------------------------------------
	logic [15:0]        yaw_ph;
	logic [15:0]        pitch_ph;
	logic signed [15:0] trig [4];

	if (ANGLE_WIDTH >= 16) begin : g_ph_hi
		assign yaw_ph   = yaw_q[ANGLE_WIDTH-1 -: 16];
		assign pitch_ph = pitch_q[ANGLE_WIDTH-1 -: 16];
	end else begin : g_ph_lo
		assign yaw_ph   = {yaw_q, {(16 - ANGLE_WIDTH){1'b0}}};
		assign pitch_ph = {pitch_q, {(16 - ANGLE_WIDTH){1'b0}}};
	end

	for (genvar g = 0; g < 4; g++) begin : g_trig
		logic [15:0]        base;
		logic [15:0]        ph;
		logic [14:0]        t_c;
		logic [29:0]        m_tt;
		logic [25:0]        m_sc;
		logic [28:0]        m_sr;
		logic [29:0]        m_tr;
		logic [14:0]        t1_q, t2_q, t3_q, t4_q;
		logic               n1_q, n2_q, n3_q, n4_q;
		logic [14:0]        sq2_q, sq3_q;
		logic [13:0]        r3_q;
		logic [14:0]        r4_q;
		logic [14:0]        mag;
		logic signed [15:0] val_q;

		assign base = (g < 2) ? yaw_ph : pitch_ph;
		assign ph   = (g % 2 == 1) ? base + vrp_pkg::QUARTER_TURN : base;
		// Odd quadrants mirror the first quadrant.
		assign t_c  = ph[14] ? vrp_pkg::TRIG_ONE - {1'b0, ph[13:0]} : {1'b0, ph[13:0]};
		assign m_tt = {15'd0, t1_q} * {15'd0, t1_q};
		assign m_sc = {11'd0, sq2_q} * {15'd0, vrp_pkg::POLY_C};
		assign m_sr = {14'd0, sq3_q} * {15'd0, r3_q};
		assign m_tr = {15'd0, t4_q} * {15'd0, r4_q};
		assign mag  = (m_tr[29:14] > {1'b0, vrp_pkg::TRIG_ONE}) ? vrp_pkg::TRIG_ONE
			: m_tr[28:14];

		always_ff @(posedge clk) begin
			t1_q  <= t_c;
			n1_q  <= ph[15];
			t2_q  <= t1_q;
			n2_q  <= n1_q;
			sq2_q <= m_tt[28:14];
			t3_q  <= t2_q;
			n3_q  <= n2_q;
			sq3_q <= sq2_q;
			r3_q  <= vrp_pkg::POLY_B - {2'd0, m_sc[25:14]};
			t4_q  <= t3_q;
			n4_q  <= n3_q;
			r4_q  <= vrp_pkg::POLY_A - m_sr[28:14];
			val_q <= n4_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end

		assign trig[g] = val_q;
	end

	// ------------------------------------------------------------------
	// Pipeline control: every stage advances together unless the output
	// register holds a result that the receiver has not taken.
	// ------------------------------------------------------------------
	logic out_valid_q;
	logic en;

	assign en       = ~out_valid_q | m_tready;
	assign s_tready = en;

	// Stages s1 to s6: the vertex waits while sine and cosine settle.
	logic [3*W-1:0] dly_s [DLY];
	logic [DLY-1:0] dlyv_s;

	// Stage s7: yaw products. Stage s8: yaw sums.
	logic signed [W+15:0] xcy_s7, zsy_s7, zcy_s7, xsy_s7;
	logic signed [W-1:0]  y_s7, y_s8;
	logic signed [W+17:0] accx, accz;
	logic signed [XW-1:0] x1_s8, z1_s8, x1_s9, x1_s10;

	// Stage s9: pitch products. Stage s10: pitch sums.
	logic signed [XW+15:0] z1sp_s9, z1cp_s9;
	logic signed [W+15:0]  ycp_s9, ysp_s9;
	logic signed [YW+14:0] accy2, accz2;
	logic signed [YW-1:0]  y2_s10, z2_s10;

	// Stage s11: depth and focal products.
	logic signed [DW-1:0]  d_s11;
	logic signed [XW+10:0] nx_s11;
	logic signed [YW+10:0] ny_s11;
	logic                  cxs_s11, cys_s11;
	logic                  v_s7, v_s8, v_s9, v_s10, v_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlyv_s <= '0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			v_s10  <= 1'b0;
			v_s11  <= 1'b0;
		end else if (en) begin
			dlyv_s <= {dlyv_s[DLY-2:0], s_tvalid};
			v_s7   <= dlyv_s[DLY-1];
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			v_s10  <= v_s9;
			v_s11  <= v_s10;
		end
	end

	assign accx  = (W+18)'(xcy_s7) + (W+18)'(zsy_s7) + (W+18)'(8192);
	assign accz  = (W+18)'(zcy_s7) - (W+18)'(xsy_s7) + (W+18)'(8192);
	assign accy2 = (YW+15)'(ycp_s9) - (YW+15)'(z1sp_s9) + (YW+15)'(8192);
	assign accz2 = (YW+15)'(ysp_s9) + (YW+15)'(z1cp_s9) + (YW+15)'(8192);

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= s_tdata[3*W-1:0];
			for (int i = 1; i < DLY; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
			// x1 = x cos(yaw) + z sin(yaw), z1 = z cos(yaw) - x sin(yaw)
			xcy_s7  <= $signed(dly_s[DLY-1][W-1:0]) * trig[1];
			zsy_s7  <= $signed(dly_s[DLY-1][3*W-1:2*W]) * trig[0];
			zcy_s7  <= $signed(dly_s[DLY-1][3*W-1:2*W]) * trig[1];
			xsy_s7  <= $signed(dly_s[DLY-1][W-1:0]) * trig[0];
			y_s7    <= $signed(dly_s[DLY-1][2*W-1:W]);
			// Rounded to nearest, halves upwards; the shift is a floor.
			x1_s8   <= accx[W+16:14];
			z1_s8   <= accz[W+16:14];
			y_s8    <= y_s7;
			// y2 = y cos(pitch) - z1 sin(pitch), z2 = y sin(pitch) + z1 cos(pitch)
			ycp_s9  <= y_s8 * trig[3];
			ysp_s9  <= y_s8 * trig[2];
			z1sp_s9 <= z1_s8 * trig[2];
			z1cp_s9 <= z1_s8 * trig[3];
			x1_s9   <= x1_s8;
			y2_s10  <= accy2[YW+13:14];
			z2_s10  <= accz2[YW+13:14];
			x1_s10  <= x1_s9;
			d_s11   <= DW'(z2_s10) + DW'($signed({1'b0, depth_q}));
			nx_s11  <= x1_s10 * $signed({1'b0, focal_q});
			ny_s11  <= y2_s10 * $signed({1'b0, focal_q});
			cxs_s11 <= x1_s10[XW-1];
			cys_s11 <= y2_s10[YW-1];
		end
	end

	// ------------------------------------------------------------------
	// Divider. Stage 0 holds |num| * 16 + d / 2; each further stage retires
	// one quotient bit. Dividend and quotient share one shift register.
	// ------------------------------------------------------------------
	logic signed [YW+11:0] nxe, nye;
	logic [YW+10:0]        absx, absy;
	logic [QW-1:0]         nqx_s [QW+1];
	logic [QW-1:0]         nqy_s [QW+1];
	logic [DVW-1:0]        remx_s [QW+1];
	logic [DVW-1:0]        remy_s [QW+1];
	logic [DVW-1:0]        dv_s [QW+1];
	logic [QW:0]           dvld_s, beh_s, negx_s, negy_s, cxs_s, cys_s;
	logic [DVW:0]          trx [QW];
	logic [DVW:0]          try [QW];
	logic [DVW-1:0]        remx_n [QW];
	logic [DVW-1:0]        remy_n [QW];
	logic [QW-1:0]         qbx, qby;

	assign nxe  = (YW+12)'(nx_s11);
	assign nye  = (YW+12)'(ny_s11);
	assign absx = nxe[YW+11] ? YW'(0) + (YW+11)'(-nxe) : nxe[YW+10:0];
	assign absy = nye[YW+11] ? YW'(0) + (YW+11)'(-nye) : nye[YW+10:0];

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			trx[k] = {remx_s[k], nqx_s[k][QW-1]};
			try[k] = {remy_s[k], nqy_s[k][QW-1]};
			qbx[k] = (trx[k] >= {1'b0, dv_s[k]});
			qby[k] = (try[k] >= {1'b0, dv_s[k]});
			remx_n[k] = qbx[k] ? DVW'(trx[k] - {1'b0, dv_s[k]}) : trx[k][DVW-1:0];
			remy_n[k] = qby[k] ? DVW'(try[k] - {1'b0, dv_s[k]}) : try[k][DVW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s <= '0;
		end else if (en) begin
			dvld_s <= {dvld_s[QW-1:0], v_s11};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nqx_s[0]  <= QW'({absx, 4'b0}) + QW'(d_s11[DW-2:1]);
			nqy_s[0]  <= QW'({absy, 4'b0}) + QW'(d_s11[DW-2:1]);
			remx_s[0] <= '0;
			remy_s[0] <= '0;
			dv_s[0]   <= d_s11[DVW-1:0];
			beh_s     <= {beh_s[QW-1:0], (d_s11 <= DW'(0))};
			negx_s    <= {negx_s[QW-1:0], nx_s11[XW+10]};
			negy_s    <= {negy_s[QW-1:0], ny_s11[YW+10]};
			cxs_s     <= {cxs_s[QW-1:0], cxs_s11};
			cys_s     <= {cys_s[QW-1:0], cys_s11};
			for (int k = 0; k < QW; k++) begin
				nqx_s[k+1]  <= {nqx_s[k][QW-2:0], qbx[k]};
				nqy_s[k+1]  <= {nqy_s[k][QW-2:0], qby[k]};
				remx_s[k+1] <= remx_n[k];
				remy_s[k+1] <= remy_n[k];
				dv_s[k+1]   <= dv_s[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Sign stage, then centre offset and saturation into the output.
	// ------------------------------------------------------------------
	logic signed [QW:0]   vx_sn, vy_sn;
	logic                 beh_sn, cxs_sn, cys_sn, v_sn;
	logic signed [SW-1:0] sumx, sumy;
	logic                 satx, saty;
	logic [W-1:0]         scrx, scry;
	logic [W-1:0]         screen_x_q, screen_y_q;
	logic                 behind_q, clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_sn        <= dvld_s[QW];
			out_valid_q <= v_sn;
		end
	end

	assign sumx = SW'(vx_sn) + SW'($signed({1'b0, center_x_q, 4'b0}));
	assign sumy = SW'(vy_sn) + SW'($signed({1'b0, center_y_q, 4'b0}));

	always_comb begin
		satx = 1'b1;
		saty = 1'b1;
		if (beh_sn) begin
			// Behind the camera the point goes to the edge its coordinate faces.
			scrx = cxs_sn ? SMIN[W-1:0] : SMAX[W-1:0];
			scry = cys_sn ? SMIN[W-1:0] : SMAX[W-1:0];
		end else begin
			if (sumx > SMAX) begin
				scrx = SMAX[W-1:0];
			end else if (sumx < SMIN) begin
				scrx = SMIN[W-1:0];
			end else begin
				scrx = sumx[W-1:0];
				satx = 1'b0;
			end
			if (sumy > SMAX) begin
				scry = SMAX[W-1:0];
			end else if (sumy < SMIN) begin
				scry = SMIN[W-1:0];
			end else begin
				scry = sumy[W-1:0];
				saty = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_sn      <= negx_s[QW] ? -$signed({1'b0, nqx_s[QW]}) : $signed({1'b0, nqx_s[QW]});
			vy_sn      <= negy_s[QW] ? -$signed({1'b0, nqy_s[QW]}) : $signed({1'b0, nqy_s[QW]});
			beh_sn     <= beh_s[QW];
			cxs_sn     <= cxs_s[QW];
			cys_sn     <= cys_s[QW];
			screen_x_q <= scrx;
			screen_y_q <= scry;
			behind_q   <= beh_sn;
			clipped_q  <= satx | saty;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({screen_y_q, screen_x_q});
	assign m_tuser  = {clipped_q, behind_q};

endmodule

// ----- src/vrp_checker.sv -----
// ----------------------------------------------------------------------------
// vrp_checker: port-level checks for the vertex rotate and project block
// Watches the output stream and the flow control over time.
// ----------------------------------------------------------------------------
module vrp_checker #(
	parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF,
	localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	// A point behind the camera is always reported as clipped.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1])
		else $error("behind_camera without clipped");

	// A point behind the camera sits on the saturation limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata[COORD_WIDTH-1:0] == CMAX || m_tdata[COORD_WIDTH-1:0] == CMIN) &&
			(m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] == CMAX ||
			 m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] == CMIN))
		else $error("behind_camera result not saturated");

	// With the output register empty the block must take a vertex.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind vertex_rotate_project vrp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vertex_rotate_project
// Drives vertices under random stream idling and register settings, predicts
// each projected point in fixed point and checks the results in order.
// ----------------------------------------------------------------------------

// Keeps the predicted projections of accepted vertices and checks results.
class projection_scoreboard;
	logic [35:0] pending[$];   // {clipped, behind, screen_y, screen_x}
	int          mismatches;

	function void note_vertex(logic [35:0] predicted);
		pending.push_back(predicted);
	endfunction

	function void check_point(logic [31:0] tdata, logic [1:0] tuser);
		logic [35:0] want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected point x=%h y=%h user=%b",
					tdata[15:0], tdata[31:16], tuser);
			return;
		end
		want = pending.pop_front();
		if (want[15:0] !== tdata[15:0] || want[31:16] !== tdata[31:16] ||
		    want[32] !== tuser[0] || want[33] !== tuser[1]) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"point mismatch: expected x=%h y=%h behind=%b clip=%b, ",
					"got x=%h y=%h behind=%b clip=%b"},
					want[15:0], want[31:16], want[32], want[33],
					tdata[15:0], tdata[31:16], tuser[0], tuser[1]);
		end
	endfunction
endclass

module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	vertex_rotate_project u_dut (.*);

	// Shadow copy of the registers used by the predictor.
	logic [15:0] yaw_q, pitch_q;
	logic [9:0]  focal_q;
	logic [11:0] cx_q, cy_q;
	logic [14:0] depth_q;

	projection_scoreboard points = new();
	int  send_idle, recv_idle;    // idle chance in percent
	bit  hold_recv;               // long receiver hold-off
	int  hold_len;
	longint cycles;

	initial forever #5 clk = ~clk;

	// Generous run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random idling plus a counted hold-off when asked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				points.check_point(m_tdata, m_tuser);
			if (hold_recv) begin
				m_tready <= 1'b0;
				hold_len++;
				if (hold_len >= 300)
					hold_recv = 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic logic [14:0] quarter_sine(logic [14:0] t);
		logic [31:0] t2, r;
		t2 = (32'(t) * 32'(t)) >> 14;
		r = 32'd10512 - ((t2 * 32'd1160) >> 14);
		r = 32'd25736 - ((t2 * r) >> 14);
		r = (32'(t) * r) >> 14;
		if (r > 32'd16384) r = 32'd16384;
		return r[14:0];
	endfunction

	function automatic int sine_q14(logic [15:0] p);
		int s;
		// Odd quadrants mirror the first; the mirrored argument can reach a full quarter.
		s = p[14] ? int'(quarter_sine(15'(16384 - int'(p[13:0]))))
		          : int'(quarter_sine({1'b0, p[13:0]}));
		return p[15] ? -s : s;
	endfunction

	function automatic longint rotate_sum(longint a, int ka, longint b, int kb);
		return (a * ka + b * kb + 8192) >>> 14;
	endfunction

	function automatic logic [15:0] project_axis(longint c, longint d, logic [11:0] centre,
	                                            bit behind, inout bit sat);
		longint v, mag, q;
		if (behind) begin
			sat = 1;
			return (c >= 0) ? 16'h7fff : 16'h8000;
		end
		v = c * longint'(focal_q) * 16;
		mag = (v < 0) ? -v : v;
		q = (mag + d / 2) / d;
		v = ((v < 0) ? -q : q) + longint'(centre) * 16;
		if (v > 32767) begin sat = 1; return 16'h7fff; end
		if (v < -32768) begin sat = 1; return 16'h8000; end
		return v[15:0];
	endfunction

	function automatic logic [35:0] predict_point(logic [47:0] v);
		longint x, y, z, x1, z1, y2, z2, d;
		int cyw, syw, cp, sp;
		bit behind, sat;
		logic [15:0] sx, sy;
		x = longint'($signed(v[15:0]));
		y = longint'($signed(v[31:16]));
		z = longint'($signed(v[47:32]));
		cyw = sine_q14(yaw_q + 16'd16384);
		syw = sine_q14(yaw_q);
		cp = sine_q14(pitch_q + 16'd16384);
		sp = sine_q14(pitch_q);
		x1 = rotate_sum(x, cyw, z, syw);
		z1 = rotate_sum(z, cyw, x, -syw);
		y2 = rotate_sum(y, cp, z1, -sp);
		z2 = rotate_sum(y, sp, z1, cp);
		d = z2 + longint'(depth_q);
		behind = (d <= 0);
		sat = 0;
		sx = project_axis(x1, d, cx_q, behind, sat);
		sy = project_axis(y2, d, cy_q, behind, sat);
		return 36'({sat, behind, sy, sx});
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			vrp_pkg::REG_YAW:      yaw_q = value[15:0];
			vrp_pkg::REG_PITCH:    pitch_q = value[15:0];
			vrp_pkg::REG_FOCAL:    focal_q = value[9:0];
			vrp_pkg::REG_CENTER_X: cx_q = value[11:0];
			vrp_pkg::REG_CENTER_Y: cy_q = value[11:0];
			vrp_pkg::REG_DEPTH:    depth_q = value[14:0];
			default: ;
		endcase
	endtask

	// Offers one vertex, with random idle cycles first, and waits for acceptance.
	task automatic send_vertex(logic [47:0] v);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		points.note_vertex(predict_point(v));
	endtask

	task automatic drain();
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (points.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(8192)) - 4096);
			2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(16384)) - 8192);
		endcase
	endfunction

	task automatic random_config();
		write_reg(vrp_pkg::REG_YAW, $urandom);
		write_reg(vrp_pkg::REG_PITCH, ($urandom_range(9) == 0) ? $urandom :
			32'($urandom_range(32768) - 16384));
		write_reg(vrp_pkg::REG_FOCAL, $urandom_range(1023));
		write_reg(vrp_pkg::REG_CENTER_X, $urandom);
		write_reg(vrp_pkg::REG_CENTER_Y, $urandom);
		write_reg(vrp_pkg::REG_DEPTH, $urandom);
	endtask

	initial begin
		logic [15:0] ext[4];
		yaw_q = '0; pitch_q = '0; focal_q = vrp_pkg::FOCAL_RESET;
		cx_q = vrp_pkg::CENTER_X_RESET; cy_q = vrp_pkg::CENTER_Y_RESET;
		depth_q = vrp_pkg::DEPTH_RESET;
		send_idle = 0; recv_idle = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes of the coordinates at reset settings.
		ext = '{16'h0000, 16'h7fff, 16'h8000, 16'h1000};
		for (int i = 0; i < 4; i++)
			send_vertex({ext[(i + 2) % 4], ext[(i + 1) % 4], ext[i]});
		// Behind camera: a strongly negative depth with a small offset.
		send_vertex({16'h8000, 16'h0100, 16'hff00});
		send_vertex({16'h8000, 16'hff00, 16'h0100});
		drain();
		// Focal length zero places every point at the centre.
		write_reg(vrp_pkg::REG_FOCAL, 0);
		send_vertex({16'h1000, 16'h7fff, 16'h8000});
		drain();
		// Large focal and extreme centre force overflow; pitch past a quarter turn.
		write_reg(vrp_pkg::REG_FOCAL, 1023);
		write_reg(vrp_pkg::REG_CENTER_X, 4095);
		write_reg(vrp_pkg::REG_CENTER_Y, 0);
		write_reg(vrp_pkg::REG_DEPTH, 32767);
		write_reg(vrp_pkg::REG_PITCH, 32'h0000_8000);
		write_reg(vrp_pkg::REG_YAW, 32'h0000_ffff);
		send_vertex({16'h0000, 16'h7fff, 16'h7fff});
		send_vertex({16'h8000, 16'h8000, 16'h8000});
		drain();
		write_reg(vrp_pkg::REG_PITCH, 16384);
		write_reg(vrp_pkg::REG_YAW, 16384);
		write_reg(vrp_pkg::REG_DEPTH, 0);
		send_vertex({16'h0000, 16'h0000, 16'h0000});
		send_vertex({16'h0001, 16'h7fff, 16'h8000});
		drain();
		write_reg(vrp_pkg::REG_PITCH, 32'hffff_c000);
		write_reg(vrp_pkg::REG_CENTER_X, 0);
		write_reg(vrp_pkg::REG_CENTER_Y, 4095);
		send_vertex({16'h0800, 16'hf000, 16'h0400});
		drain();

		// Random part: receiver-idle phases, then sender-idle phases, then
		// free streaming with one long receiver hold-off.
		for (int phase = 0; phase < 8; phase++) begin
			random_config();
			send_idle = (phase < 3) ? 35 : (phase < 6) ? 86 : 0;
			recv_idle = (phase < 3) ? 86 : (phase < 6) ? 35 : 0;
			if (phase == 6) begin
				hold_len = 0;
				hold_recv = 1'b1;
			end
			for (int n = 0; n < 200; n++)
				send_vertex({rand_coord(), rand_coord(), rand_coord()});
			drain();
		end

		if (points.mismatches == 0 && points.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
src/vrp_pkg.sv
src/vertex_rotate_project.sv
src/vrp_checker.sv
tb/sv/testbench.sv
